// ===== src/dmpt_pkg.sv =====
`timescale 1ns / 1ps
package dmpt_pkg;

  typedef enum logic {
    CMD_WRITE_KEY = 1'b0,
    CMD_UPDATE    = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_KEY_COUNT   = 2'd0,
    CFG_ANIM_LENGTH = 2'd1,
    CFG_MATCH_EN    = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic        is_update;
    logic [5:0]  key_index;
    logic [31:0] key_value;
    logic [31:0] key_time;
    logic [31:0] distance;
    logic [31:0] delta_time;
  } item_t;

  typedef struct packed {
    logic  avail;
    item_t head;
  } queue_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SCMP,
    ST_RDB,
    ST_PREP,
    ST_DIV,
    ST_ALPHA,
    ST_MUL0,
    ST_MUL1,
    ST_SHIFT,
    ST_TGT,
    ST_FINISH
  } state_t;

  localparam int DIV_STEPS = 24;

endpackage

// ===== src/distance_matched_playback_time.sv =====
`timescale 1ns / 1ps
// Distance-matched playback time. The back end stores a key write straight from idle.
// An update, with matching on and at least two keys, runs a binary search over the
// single-port key table and, unless the bracketing key values are equal, the
// two-bit-per-cycle divider for the interpolation fraction. A two-entry queue takes
// items ahead of the back end; busy is high while it is full. Each update gives
// play_time with a one-cycle done pulse that the receiver cannot stall.
module distance_matched_playback_time
  import dmpt_pkg::*;
#(
  parameter int MAX_KEYS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [5:0]  key_index,
  input  logic [31:0] key_value,
  input  logic [31:0] key_time,
  input  logic [31:0] distance,
  input  logic [31:0] delta_time,
  output logic [31:0] play_time,
  output logic        done,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic [6:0]  key_count;
  logic [31:0] anim_length;
  logic        matching_enable;
  logic        pop;
  queue_out_t  qout;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count       <= 7'd0;
      anim_length     <= 32'd0;
      matching_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KEY_COUNT:   key_count <= cfg_data[6:0];
        CFG_ANIM_LENGTH: anim_length <= cfg_data;
        CFG_MATCH_EN:    matching_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  dmpt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .command    (command),
    .key_index  (key_index),
    .key_value  (key_value),
    .key_time   (key_time),
    .distance   (distance),
    .delta_time (delta_time),
    .pop        (pop),
    .busy       (busy),
    .qout       (qout)
  );

  dmpt_back #(.MAX_KEYS(MAX_KEYS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .qout            (qout),
    .pop             (pop),
    .key_count       (key_count),
    .anim_length     (anim_length),
    .matching_enable (matching_enable),
    .play_time       (play_time),
    .done            (done)
  );
endmodule

// ===== src/dmpt_ram.sv =====
`timescale 1ns / 1ps
module dmpt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== src/dmpt_front.sv =====
`timescale 1ns / 1ps
module dmpt_front
  import dmpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        command,
  input  logic [5:0]  key_index,
  input  logic [31:0] key_value,
  input  logic [31:0] key_time,
  input  logic [31:0] distance,
  input  logic [31:0] delta_time,
  input  logic        pop,
  output logic        busy,
  output queue_out_t  qout
);
  item_t      fq [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;
  item_t      in_item;

  assign busy = (cnt == 2'd2);
  assign push = start && !busy;

  always_comb begin
    in_item.is_update  = (command == CMD_UPDATE);
    in_item.key_index  = key_index;
    in_item.key_value  = key_value;
    in_item.key_time   = key_time;
    in_item.distance   = distance;
    in_item.delta_time = delta_time;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fq[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  assign qout.avail = (cnt != 2'd0);
  assign qout.head  = fq[rd_ptr];
endmodule

// ===== src/dmpt_back.sv =====
`timescale 1ns / 1ps
module dmpt_back
  import dmpt_pkg::*;
#(
  parameter int MAX_KEYS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  queue_out_t  qout,
  output logic        pop,
  input  logic [6:0]  key_count,
  input  logic [31:0] anim_length,
  input  logic        matching_enable,
  output logic [31:0] play_time,
  output logic        done
);
  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NW = $clog2(MAX_KEYS + 1);

  state_t state, state_next;

  logic [AW-1:0]      first, count, half, mid, ram_addr;
  logic               ram_we;
  logic [63:0]        rdata;
  logic [NW-1:0]      n;
  logic signed [31:0] query_dist;
  logic [31:0]        delta, av, at, dvs, dm, target, ptr;
  logic [31:0]        rem;
  logic [47:0]        quo;
  logic [4:0]         dcnt;
  logic               sn, sd, ps, hold;
  logic [48:0]        am;
  logic [63:0]        p0;
  logic [48:0]        p1;
  logic [65:0]        sh;
  logic               slot_ok, go_key;

  logic signed [32:0] diff, nd, dt;
  logic [32:0]        diff_mag, nd_mag, dt_mag;
  logic [31:0]        rem_n;
  logic [47:0]        quo_n;
  logic [80:0]        pm;
  logic [34:0]        s35;
  logic [32:0]        t33;

  assign n = ({25'd0, key_count} > 32'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(key_count);
  assign slot_ok = ({26'd0, qout.head.key_index} < 32'(MAX_KEYS));
  assign go_key = ({{(32-NW){1'b0}}, n} >= 32'd2);
  assign half = count >> 1;
  assign mid = first + half;

  dmpt_ram #(.WIDTH(64), .DEPTH(MAX_KEYS)) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({qout.head.key_value, qout.head.key_time}),
    .rdata (rdata)
  );

  always_comb begin
    diff     = $signed({rdata[63], rdata[63:32]}) - $signed({av[31], av});
    nd       = $signed({query_dist[31], query_dist}) - $signed({av[31], av});
    dt       = $signed({1'b0, rdata[31:0]}) - $signed({1'b0, at});
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    nd_mag   = nd[32] ? 33'(-nd) : 33'(nd);
    dt_mag   = dt[32] ? 33'(-dt) : 33'(dt);
  end

  // two restoring steps per cycle
  always_comb begin
    logic [32:0] r;
    rem_n = rem;
    quo_n = quo;
    for (int i = 0; i < 2; i++) begin
      r     = {rem_n, quo_n[47]};
      quo_n = {quo_n[46:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        r        = r - {1'b0, dvs};
        quo_n[0] = 1'b1;
      end
      rem_n = r[31:0];
    end
  end

  always_comb begin
    pm = {17'd0, p0} + {p1, 32'd0};
    if (ps) begin
      s35 = {2'b0, at} - {2'b0, sh[32:0]};
    end else begin
      s35 = {2'b0, at} + {2'b0, sh[32:0]};
    end
    t33 = (target > ptr) ? {1'b0, target} : ({1'b0, ptr} + {1'b0, delta});
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (qout.avail && qout.head.is_update) begin
          state_next = (matching_enable && go_key) ? ST_SEARCH : ST_FINISH;
        end
      end
      ST_SEARCH: state_next = (count == '0) ? ST_RDB : ST_SCMP;
      ST_SCMP:   state_next = ST_SEARCH;
      ST_RDB:    state_next = ST_PREP;
      ST_PREP:   state_next = (diff == '0) ? ST_FINISH : ST_DIV;
      ST_DIV:    state_next = (dcnt == 5'(DIV_STEPS - 1)) ? ST_ALPHA : ST_DIV;
      ST_ALPHA:  state_next = ST_MUL0;
      ST_MUL0:   state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_SHIFT;
      ST_SHIFT:  state_next = ST_TGT;
      ST_TGT:    state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    ram_we   = 1'b0;
    ram_addr = AW'(qout.head.key_index);
    unique case (state)
      ST_IDLE: begin
        pop    = qout.avail;
        ram_we = qout.avail && !qout.head.is_update && slot_ok;
      end
      ST_SEARCH: ram_addr = (count == '0) ? first - AW'(1) : mid;
      ST_RDB:    ram_addr = first;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ptr   <= 32'd0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_FINISH);
      if (state == ST_FINISH && !hold) begin
        ptr <= (t33 > {1'b0, anim_length}) ? anim_length : t33[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        query_dist <= $signed(qout.head.distance);
        delta      <= qout.head.delta_time;
        hold       <= !matching_enable;
        first      <= AW'(1);
        count      <= AW'(n - NW'(2));
        target     <= 32'd0;
      end
      ST_SCMP: begin
        if (query_dist > $signed(rdata[63:32])) begin
          first <= mid + AW'(1);
          count <= count - half - AW'(1);
        end else begin
          count <= half;
        end
      end
      ST_RDB: begin
        av <= rdata[63:32];
        at <= rdata[31:0];
      end
      ST_PREP: begin
        target <= at;
        dvs    <= diff_mag[31:0];
        sn     <= nd[32] ^ diff[32];
        rem    <= 32'd0;
        quo    <= {nd_mag[31:0], 16'd0};
        dcnt   <= 5'd0;
        dm     <= dt_mag[31:0];
        sd     <= dt[32];
      end
      ST_DIV: begin
        rem  <= rem_n;
        quo  <= quo_n;
        dcnt <= dcnt + 5'd1;
      end
      ST_ALPHA: begin
        am <= {1'b0, quo} + 49'(sn && (rem != 32'd0));
        ps <= sn ^ sd;
      end
      ST_MUL0: p0 <= am[31:0] * dm;
      ST_MUL1: p1 <= am[48:32] * dm;
      ST_SHIFT: sh <= {1'b0, pm[80:16]} + 66'(ps && (pm[15:0] != 16'd0));
      ST_TGT: begin
        if (sh[65:33] != '0) begin
          target <= ps ? 32'd0 : 32'hFFFF_FFFF;
        end else if (s35[34]) begin
          target <= 32'd0;
        end else if (s35[33:32] != 2'd0) begin
          target <= 32'hFFFF_FFFF;
        end else begin
          target <= s35[31:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign play_time = ptr;
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import dmpt_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int SETTLE_CYCLES = 80;
  localparam longint CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        command;
  logic [5:0]  key_index;
  logic [31:0] key_value;
  logic [31:0] key_time;
  logic [31:0] distance;
  logic [31:0] delta_time;
  logic [31:0] play_time;
  logic        done;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  distance_matched_playback_time uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .key_index(key_index), .key_value(key_value), .key_time(key_time),
    .distance(distance), .delta_time(delta_time), .play_time(play_time),
    .done(done), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [31:0] curve_values [TABLE_DEPTH];
  logic [31:0] curve_times [TABLE_DEPTH];
  bit          slot_written [TABLE_DEPTH];
  logic [31:0] held_time;
  logic [6:0]  num_keys;
  logic [31:0] length_limit;
  logic        match_on;

  logic [31:0] expected_times [$];
  int          error_count = 0;
  longint      cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[distance_matched_playback_time] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_times.size() == 0) begin
        $error("play_time: unexpected result, actual %h", play_time);
        error_count++;
      end else begin
        if (play_time !== expected_times[0]) begin
          $error("play_time: expected %h, actual %h", expected_times[0], play_time);
          error_count++;
        end
        void'(expected_times.pop_front());
      end
    end
  end

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic logic [31:0] interp_target(longint query_dist);
    int unsigned n, first, count, half, mid;
    longint av, bv, at, bt, diff, num, alpha, dt, mag, amag, target;
    n = (num_keys > TABLE_DEPTH) ? TABLE_DEPTH : num_keys;
    if (n < 2) return 32'd0;
    first = 1;
    count = n - 2;
    while (count > 0) begin
      half = count / 2;
      mid = first + half;
      if (query_dist > longint'($signed(curve_values[mid]))) begin
        first = mid + 1;
        count -= half + 1;
      end else begin
        count = half;
      end
    end
    av = longint'($signed(curve_values[first - 1]));
    bv = longint'($signed(curve_values[first]));
    at = longint'({32'd0, curve_times[first - 1]});
    bt = longint'({32'd0, curve_times[first]});
    diff = bv - av;
    if (diff == 0) return at[31:0];
    num = (query_dist - av) * 65536;
    if (diff < 0) begin
      diff = -diff;
      num = -num;
    end
    alpha = floor_quot(num, diff);
    dt = bt - at;
    if (dt == 0 || alpha == 0) return at[31:0];
    mag = dt < 0 ? -dt : dt;
    amag = alpha < 0 ? -alpha : alpha;
    if (amag > 64'sh7FFFFFFFFFFFFFFF / mag)
      return ((alpha < 0) != (dt < 0)) ? 32'd0 : 32'hFFFFFFFF;
    target = at + floor_quot(alpha * dt, 65536);
    if (target < 0) return 32'd0;
    if (target > 64'sh00000000FFFFFFFF) return 32'hFFFFFFFF;
    return target[31:0];
  endfunction

  function automatic void predict_item(cmd_t cmd, logic [5:0] slot, logic [31:0] kv,
                                       logic [31:0] kt, logic [31:0] query_dist,
                                       logic [31:0] dlt);
    logic [31:0] tgt;
    logic [32:0] next;
    if (cmd == CMD_WRITE_KEY) begin
      curve_values[slot] = kv;
      curve_times[slot] = kt;
      slot_written[slot] = 1'b1;
      return;
    end
    if (match_on) begin
      tgt = interp_target(longint'($signed(query_dist)));
      if (tgt > held_time) next = {1'b0, tgt};
      else next = {1'b0, held_time} + {1'b0, dlt};
      if (next > {1'b0, length_limit}) next = {1'b0, length_limit};
      held_time = next[31:0];
    end
    expected_times.push_back(held_time);
  endfunction

  task automatic send_item(cmd_t cmd, logic [5:0] slot, logic [31:0] kv, logic [31:0] kt,
                           logic [31:0] query_dist, logic [31:0] dlt);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    key_index <= slot;
    key_value <= kv;
    key_time <= kt;
    distance <= query_dist;
    delta_time <= dlt;
    do @(posedge clk); while (busy);
    predict_item(cmd, slot, kv, kt, query_dist, dlt);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (expected_times.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_KEY_COUNT: num_keys = value[6:0];
      CFG_ANIM_LENGTH: length_limit = value;
      CFG_MATCH_EN: match_on = value[0];
      default: ;
    endcase
  endtask

  // slots below count must all be written before an update reads them
  task automatic fill_sorted(int n);
    logic [31:0] v;
    logic [31:0] t;
    v = 32'h8000_0000 + $urandom_range(0, 255);
    t = $urandom_range(0, 65535);
    for (int i = 0; i < n; i++) begin
      send_item(CMD_WRITE_KEY, i[5:0], v, t, $urandom, $urandom);
      v = v + $urandom_range(1, 32'h0300_0000);
      t = t + $urandom_range(0, 32'h0004_0000);
    end
  endtask

  function automatic int valid_keys();
    int n;
    n = (num_keys > TABLE_DEPTH) ? TABLE_DEPTH : num_keys;
    for (int i = 0; i < n; i++)
      if (!slot_written[i]) return i;
    return n;
  endfunction

  task automatic test_directed();
    write_reg(CFG_ANIM_LENGTH, 32'hFFFF_FFFF);
    send_item(CMD_UPDATE, 6'd0, 0, 0, 32'h0001_0000, 32'h0000_8000);
    send_item(CMD_WRITE_KEY, 6'd0, 32'h0000_0000, 32'h0000_0000, 0, 0);
    send_item(CMD_WRITE_KEY, 6'd1, 32'h0000_0000, 32'h0005_0000, 0, 0);
    send_item(CMD_WRITE_KEY, 6'd2, 32'h0010_0000, 32'h0010_0000, 0, 0);
    send_item(CMD_WRITE_KEY, 6'd3, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    write_reg(CFG_KEY_COUNT, 32'd1);
    send_item(CMD_UPDATE, 6'd0, 0, 0, 32'h0000_1000, 32'h0000_0100);
    write_reg(CFG_KEY_COUNT, 32'd2);
    send_item(CMD_UPDATE, 6'd0, 0, 0, 32'h0000_1000, 32'h0000_0100);
    write_reg(CFG_KEY_COUNT, 32'd4);
    send_item(CMD_UPDATE, 6'd0, 0, 0, 32'h0008_0000, 32'h0000_0000);
    send_item(CMD_UPDATE, 6'd0, 0, 0, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(CMD_UPDATE, 6'd0, 0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    write_reg(CFG_ANIM_LENGTH, 32'h0000_0000);
    send_item(CMD_UPDATE, 6'd0, 0, 0, 32'h0004_0000, 32'h0001_0000);
    write_reg(CFG_ANIM_LENGTH, 32'h0020_0000);
    send_item(CMD_UPDATE, 6'd0, 0, 0, 32'h7FFF_FFFF, 32'h0001_0000);
    write_reg(CFG_MATCH_EN, 32'd0);
    send_item(CMD_UPDATE, 6'd0, 0, 0, 32'h0004_0000, 32'h0001_0000);
    write_reg(CFG_MATCH_EN, 32'd1);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    // unsorted pair with a falling time
    send_item(CMD_WRITE_KEY, 6'd0, 32'h0040_0000, 32'h0030_0000, 0, 0);
    send_item(CMD_WRITE_KEY, 6'd1, 32'hFFC0_0000, 32'h0000_0000, 0, 0);
    write_reg(CFG_KEY_COUNT, 32'd2);
    send_item(CMD_UPDATE, 6'd0, 0, 0, 32'h0000_0000, 32'h0000_0001);
    send_item(CMD_WRITE_KEY, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
  endtask

  task automatic test_random(int items);
    int n;
    int cmax;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: n = 64;
        1: n = 2;
        default: n = $urandom_range(2, 20);
      endcase
      fill_sorted(n);
      cmax = (phase == 3) ? 127 : n;
      write_reg(CFG_KEY_COUNT, cmax);
      write_reg(CFG_ANIM_LENGTH, (phase == 5) ? 32'hFFFF_FFFF : $urandom);
      write_reg(CFG_MATCH_EN, 32'((phase % 3) != 2));
      if (phase == 6) write_reg(CFG_ANIM_LENGTH, 32'h0000_0000);
      for (int k = 0; k < items / 8; k++) begin
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
          send_item(CMD_UPDATE, 6'($urandom), $urandom, $urandom,
                    ($urandom_range(0, 3) == 0) ? $urandom :
                    32'h8000_0000 + $urandom_range(0, 32'h2000_0000) * (k % 8),
                    ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h0000_2000));
        end else begin
          // overwrite keeping the written prefix contiguous
          int s;
          s = $urandom_range(0, 63);
          if (!slot_written[s] && s > valid_keys()) s = valid_keys() % TABLE_DEPTH;
          send_item(CMD_WRITE_KEY, s[5:0], $urandom, $urandom, $urandom, $urandom);
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    command = CMD_WRITE_KEY;
    key_index = '0;
    key_value = '0;
    key_time = '0;
    distance = '0;
    delta_time = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_KEY_COUNT;
    cfg_data = '0;
    held_time = '0;
    num_keys = '0;
    length_limit = '0;
    match_on = 1'b1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      curve_values[i] = '0;
      curve_times[i] = '0;
      slot_written[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(300);
    wait_idle();
    if (error_count == 0 && expected_times.size() == 0) begin
      $display("[distance_matched_playback_time] OK");
    end else begin
      if (expected_times.size() != 0)
        $error("play_time: %0d expected results never arrived", expected_times.size());
      $display("[distance_matched_playback_time] ERROR");
    end
    $finish;
  end

endmodule

// ===== distance_matched_playback_time.f =====
src/dmpt_pkg.sv
src/dmpt_ram.sv
src/dmpt_front.sv
src/dmpt_back.sv
src/distance_matched_playback_time.sv
tb/testbench.sv
